/* rtl/b64c_pkg.sv */
// ----------------------------------------------------------------------------
// b64c_pkg
// Types, character constants and alphabet functions shared by the base64
// stream codec modules.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2b;
  localparam logic [7:0] CHAR_SLASH   = 8'h2f;
  localparam logic [7:0] CHAR_PAD     = 8'h3d;

  localparam logic [6:0] SEXTET_BAD   = 7'd64;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_item;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       end_of_stream;
  } out_item_t;

  // all results caused by one input item, first result in data[0]
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      num;
    logic            eos;
    logic            nodata;
  } grp_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return CHAR_UPPER_A + w;
    end else if (v < 6'd52) begin
      return CHAR_LOWER_A + w - 8'd26;
    end else if (v < 6'd62) begin
      return CHAR_ZERO + w - 8'd52;
    end else if (v == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

  // 0..63 for an alphabet character, SEXTET_BAD otherwise
  function automatic logic [6:0] dec_sextet(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'd0;
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      d = ch - CHAR_UPPER_A;
    end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      d = ch - CHAR_LOWER_A + 8'd26;
    end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      d = ch - CHAR_ZERO + 8'd52;
    end else if (ch == CHAR_PLUS) begin
      d = 8'd62;
    end else if (ch == CHAR_SLASH) begin
      d = 8'd63;
    end else begin
      d = {1'b0, SEXTET_BAD};
    end
    return d[6:0];
  endfunction

endpackage

/* rtl/base64_stream_codec.sv */
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder/decoder with a direction register.
// ----------------------------------------------------------------------------
// An item is taken in the cycle it arrives whenever the one-group result slot
// is free, and all results it causes are formed in that same cycle; they then
// leave one per cycle while out_ready is high, from the cycle after if no
// group is ahead. The single result port bounds encode, as three bytes give
// four results. Decode takes one character per cycle unless the output
// stalls, as four characters give at most three results. Write the direction
// only while no item is in flight; the write also drops any partial group.
module base64_stream_codec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64c_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b64c_pkg::out_item_t out_data
);
  import b64c_pkg::*;

  grp_t grp;
  logic in_accept;
  logic grp_load;

  assign in_accept = in_valid && in_ready;
  assign grp_load  = in_accept && (grp.num != 3'd0);

  b64c_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .item      (in_data),
    .grp       (grp)
  );

  b64c_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_load  (grp_load),
    .grp       (grp),
    .slot_free (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // every last item produces at least one result
  a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.last_item |-> grp.num != 3'd0)
    else $error("last item produced no result");

  // the data-less marker is a lone result
  a_marker_alone: assert property (@(posedge clk) disable iff (!rst_n)
    grp.nodata |-> grp.num == 3'd1 && grp.eos)
    else $error("end marker not alone");

  // a result without data is always the end of stream and reads zero
  a_nodata_eos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_data |-> out_data.end_of_stream && out_data.out_byte == 8'd0)
    else $error("data-less result is not a clean end marker");

  // pending slot only fills behind a group being sent
  a_pend_behind: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("pending group with nothing being sent");

endmodule

/* rtl/b64c_core.sv */
// ----------------------------------------------------------------------------
// b64c_core
// Direction register, group state and the single-pass encode/decode logic
// that turns one accepted item into its group of results.
// ----------------------------------------------------------------------------
module b64c_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_accept,
  input  b64c_pkg::in_item_t  item,
  output b64c_pkg::grp_t      grp
);
  import b64c_pkg::*;

  logic        dir_r;
  logic [1:0]  gc_r, gc_nxt;
  logic [23:0] held_r, held_nxt;
  logic        stop_r, stop_nxt;

  logic [1:0]  cnt_enc;
  logic [1:0]  n_enc;
  logic [23:0] held_enc;
  logic [6:0]  sx;
  logic [23:0] held_fill;
  logic [3:0][7:0] enc_chars;

  always_comb begin
    grp       = '0;
    gc_nxt    = gc_r;
    held_nxt  = held_r;
    stop_nxt  = stop_r;
    cnt_enc   = (gc_r == 2'd3) ? 2'd2 : gc_r;
    n_enc     = cnt_enc + 2'd1;
    held_enc  = held_r;
    held_fill = held_r;
    sx        = dec_sextet(item.in_byte);

    case (cnt_enc)
      2'd0:    held_enc[23:16] = held_r[23:16] | item.in_byte;
      2'd1:    held_enc[15:8]  = held_r[15:8]  | item.in_byte;
      default: held_enc[7:0]   = held_r[7:0]   | item.in_byte;
    endcase
    enc_chars[0] = enc_char(held_enc[23:18]);
    enc_chars[1] = enc_char(held_enc[17:12]);
    enc_chars[2] = enc_char(held_enc[11:6]);
    enc_chars[3] = enc_char(held_enc[5:0]);

    if (dir_r == DIR_ENCODE) begin
      if (n_enc == 2'd3) begin
        grp.data = enc_chars;
        grp.num  = 3'd4;
        gc_nxt   = 2'd0;
        held_nxt = '0;
      end else if (item.last_item) begin
        grp.data[0] = enc_chars[0];
        grp.data[1] = enc_chars[1];
        grp.data[2] = (n_enc == 2'd2) ? enc_chars[2] : CHAR_PAD;
        grp.data[3] = CHAR_PAD;
        grp.num     = 3'd4;
      end else begin
        gc_nxt   = n_enc;
        held_nxt = held_enc;
      end
    end else begin
      if (!stop_r) begin
        if (sx[6]) begin
          stop_nxt = 1'b1;
        end else begin
          case (gc_r)
            2'd0:    held_fill[23:18] = held_r[23:18] | sx[5:0];
            2'd1:    held_fill[17:12] = held_r[17:12] | sx[5:0];
            2'd2:    held_fill[11:6]  = held_r[11:6]  | sx[5:0];
            default: held_fill[5:0]   = held_r[5:0]   | sx[5:0];
          endcase
          if (gc_r == 2'd3) begin
            grp.data[0] = held_fill[23:16];
            grp.data[1] = held_fill[15:8];
            grp.data[2] = held_fill[7:0];
            grp.num     = 3'd3;
            gc_nxt      = 2'd0;
            held_nxt    = '0;
          end else begin
            gc_nxt   = gc_r + 2'd1;
            held_nxt = held_fill;
          end
        end
      end
      // flush of a partial group gives one byte fewer than characters held
      if (item.last_item && gc_nxt > 2'd1) begin
        grp.data[0] = held_nxt[23:16];
        grp.data[1] = held_nxt[15:8];
        grp.data[2] = held_nxt[7:0];
        grp.num     = {1'b0, gc_nxt - 2'd1};
      end
      if (item.last_item && grp.num == 3'd0) begin
        grp.nodata = 1'b1;
        grp.num    = 3'd1;
      end
    end

    if (item.last_item) begin
      grp.eos  = 1'b1;
      gc_nxt   = 2'd0;
      held_nxt = '0;
      stop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= DIR_ENCODE;
      gc_r   <= 2'd0;
      held_r <= '0;
      stop_r <= 1'b0;
    end else if (cfg_we) begin
      dir_r  <= cfg_wdata;
      gc_r   <= 2'd0;
      held_r <= '0;
      stop_r <= 1'b0;
    end else if (in_accept) begin
      gc_r   <= gc_nxt;
      held_r <= held_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

/* rtl/b64c_out.sv */
// ----------------------------------------------------------------------------
// b64c_out
// Result buffer: one pending group slot in front of the group being sent,
// sending one result item per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module b64c_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                grp_load,
  input  b64c_pkg::grp_t      grp,
  output logic                slot_free,
  output logic                out_valid,
  input  logic                out_ready,
  output b64c_pkg::out_item_t out_data
);
  import b64c_pkg::*;

  logic       pend_valid_r;
  grp_t       pend_r;
  logic       cur_valid_r;
  grp_t       cur_r;
  logic [1:0] idx_r;
  logic       at_last;
  logic       finishing;
  logic       cur_free;

  assign at_last   = ({1'b0, idx_r} + 3'd1) == cur_r.num;
  assign finishing = cur_valid_r && out_ready && at_last;
  assign cur_free  = !cur_valid_r || finishing;
  assign slot_free = !pend_valid_r;

  assign out_valid              = cur_valid_r;
  assign out_data.out_byte      = cur_r.nodata ? 8'd0 : cur_r.data[idx_r];
  assign out_data.has_data      = !cur_r.nodata;
  assign out_data.end_of_stream = cur_r.eos && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      cur_valid_r  <= 1'b0;
      idx_r        <= 2'd0;
    end else if (cur_free) begin
      idx_r <= 2'd0;
      if (pend_valid_r) begin
        cur_valid_r  <= 1'b1;
        pend_valid_r <= grp_load;
      end else begin
        cur_valid_r <= grp_load;
      end
    end else begin
      if (out_ready) begin
        idx_r <= idx_r + 2'd1;
      end
      if (grp_load) begin
        pend_valid_r <= 1'b1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cur_free && pend_valid_r) begin
      cur_r <= pend_r;
    end else if (cur_free && grp_load) begin
      cur_r <= grp;
    end
    if (grp_load && (pend_valid_r || !cur_free)) begin
      pend_r <= grp;
    end
  end

endmodule

/* bench/b64_stream_check.sv */
// ----------------------------------------------------------------------------
// b64_stream_check
// Watches the codec's item channels and direction writes, predicts the
// characters or bytes each accepted item produces, and compares every
// accepted result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module b64_stream_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  b64c_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  b64c_pkg::out_item_t out_data,
  output int                  mismatches,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import b64c_pkg::*;

  logic        dir_mode = DIR_ENCODE;
  int          group_cnt = 0;
  logic [23:0] group_bits = '0;
  logic        halted = 1'b0;
  out_item_t   expected_q[$];
  out_item_t   want;
  int          fail_count = 0;
  int          queued = 0;

  assign mismatches  = fail_count;
  assign outstanding = queued;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    case (v) inside
      [6'd0:6'd25]:  return CHAR_UPPER_A + 8'(v);
      [6'd26:6'd51]: return CHAR_LOWER_A + 8'(v - 6'd26);
      [6'd52:6'd61]: return CHAR_ZERO + 8'(v - 6'd52);
      6'd62:         return CHAR_PLUS;
      default:       return CHAR_SLASH;
    endcase
  endfunction

  function automatic logic [6:0] char_to_sextet(input logic [7:0] ch);
    if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) return 7'(ch - CHAR_UPPER_A);
    if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) return 7'(ch - CHAR_LOWER_A + 8'd26);
    if (ch inside {[CHAR_ZERO:CHAR_NINE]}) return 7'(ch - CHAR_ZERO + 8'd52);
    if (ch == CHAR_PLUS) return 7'd62;
    if (ch == CHAR_SLASH) return 7'd63;
    return SEXTET_BAD;
  endfunction

  function automatic void clear_group();
    group_cnt  = 0;
    group_bits = '0;
    halted     = 1'b0;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // works out the results of one item and queues them in order
  task automatic predict_results(input in_item_t it);
    out_item_t  res [4];
    int         n;
    int         cnt;
    logic [6:0] sx;
    n   = 0;
    cnt = group_cnt;
    if (dir_mode == DIR_ENCODE) begin
      group_bits[23-8*cnt -: 8] = it.in_byte;
      if (cnt == 2) begin
        for (int k = 0; k < 4; k++) begin
          res[n] = '{sextet_to_char(group_bits[23-6*k -: 6]), 1'b1, 1'b0};
          n++;
        end
        cnt        = 0;
        group_bits = '0;
      end else begin
        cnt++;
        if (it.last_item) begin
          // partial group: count+1 characters, then padding
          for (int k = 0; k < 4; k++) begin
            res[n] = '{(k <= cnt) ? sextet_to_char(group_bits[23-6*k -: 6]) : CHAR_PAD,
                       1'b1, 1'b0};
            n++;
          end
        end
      end
    end else begin
      if (!halted) begin
        sx = char_to_sextet(it.in_byte);
        if (sx == SEXTET_BAD) begin
          halted = 1'b1;
        end else begin
          group_bits[23-6*cnt -: 6] = sx[5:0];
          if (cnt == 3) begin
            for (int k = 0; k < 3; k++) begin
              res[n] = '{group_bits[23-8*k -: 8], 1'b1, 1'b0};
              n++;
            end
            cnt        = 0;
            group_bits = '0;
          end else begin
            cnt++;
          end
        end
      end
      if (it.last_item) begin
        for (int k = 0; k + 1 < cnt; k++) begin
          res[n] = '{group_bits[23-8*k -: 8], 1'b1, 1'b0};
          n++;
        end
        // nothing to flush: data-less end marker
        if (n == 0) begin
          res[n] = '{8'h00, 1'b0, 1'b1};
          n++;
        end
      end
    end
    if (it.last_item) begin
      res[n-1].end_of_stream = 1'b1;
      clear_group();
    end else begin
      group_cnt = cnt;
    end
    for (int k = 0; k < n; k++) expected_q.push_back(res[k]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dir_mode = DIR_ENCODE;
      clear_group();
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        dir_mode = cfg_wdata;
        clear_group();
      end
      if (in_valid && in_ready) predict_results(in_data);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          note_mismatch($sformatf("unexpected item %h", out_data));
        end else begin
          want = expected_q.pop_front();
          if (out_data.out_byte !== want.out_byte)
            note_mismatch($sformatf("out_byte %h, expected %h",
                                    out_data.out_byte, want.out_byte));
          if (out_data.has_data !== want.has_data)
            note_mismatch($sformatf("has_data %b, expected %b",
                                    out_data.has_data, want.has_data));
          if (out_data.end_of_stream !== want.end_of_stream)
            note_mismatch($sformatf("end_of_stream %b, expected %b",
                                    out_data.end_of_stream, want.end_of_stream));
        end
      end
    end
    queued = expected_q.size();
  end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the base64 stream codec with directed and random encode and decode
// streams under random stalls on both channels; the stream checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import b64c_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 90;
  localparam int SETTLE_CYCLES = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int mismatches;
  int queued;
  int cycle_count = 0;
  int sent = 0;
  int hold_left = 0;
  bit calm_sender = 1'b0;
  bit calm_receiver = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  base64_stream_codec DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  b64_stream_check stream_watch (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (queued)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] alpha_char();
    case ($urandom_range(0, 6))
      0, 1:    return 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
      2, 3:    return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
      4:       return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
      5:       return CHAR_PLUS;
      default: return CHAR_SLASH;
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!calm_receiver && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      hold_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    gap = calm_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, last_item: last};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send_item(s[i], close && i == s.len() - 1);
  endtask

  // hold the input until every predicted result is out, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (queued != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_direction(input logic d);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic encode_stream(input int len, input bit close);
    for (int i = 0; i < len; i++) send_item(8'($urandom_range(0, 255)), close && i == len - 1);
  endtask

  // random alphabet text, optionally padded, or broken by junk
  task automatic decode_stream(input bit close);
    int         n_alpha;
    int         tail;
    int         n_pad;
    logic [7:0] ch;
    n_alpha = $urandom_range(1, 9);
    tail    = $urandom_range(0, 9);
    for (int i = 0; i < n_alpha; i++) begin
      ch = (tail == 9 && $urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : alpha_char();
      send_item(ch, close && tail < 5 && i == n_alpha - 1);
    end
    if (tail >= 5 && tail <= 7) begin
      n_pad = $urandom_range(1, 2);
      for (int p = 0; p < n_pad; p++) send_item(CHAR_PAD, close && p == n_pad - 1);
    end else if (tail >= 8) begin
      send_item(8'($urandom_range(0, 255)), close);
    end
  endtask

  initial begin
    logic dir;
    int   n_streams;
    bit   close;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // encode from reset: full group, one-byte and two-byte tails
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'hff, 1'b1);
    send_item(8'h4d, 1'b0);
    send_item(8'h61, 1'b1);

    set_direction(DIR_DECODE);
    send_text("TWFu", 1'b1);
    send_text("az09+/", 1'b1);
    // pad alone gives only the end marker
    send_text("=", 1'b1);
    // characters after a pad are dropped, the held pair still flushes
    send_text("QQ=x", 1'b1);
    // non-ascii stops the stream
    send_item(8'h80, 1'b0);
    send_item(8'hff, 1'b1);
    send_text("Q", 1'b1);

    while (sent < 24 + RANDOM_ITEMS) begin
      dir = 1'($urandom_range(0, 1));
      set_direction(dir);
      calm_sender   = ($urandom_range(0, 3) == 0);
      calm_receiver = ($urandom_range(0, 3) == 0);
      n_streams     = $urandom_range(2, 5);
      for (int s = 0; s < n_streams; s++) begin
        // an unclosed stream runs into the next one or is dropped by the write
        close = ($urandom_range(0, 7) != 0);
        if (dir == DIR_ENCODE) encode_stream($urandom_range(1, 8), close);
        else decode_stream(close);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
